### rtl/vda_pkg.sv
// Types, constants and codes shared across the vector distance accumulator.
package vda_pkg;

	localparam int ELEM_WIDTH_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int SUM_W          = 45;
	localparam int DIST_W         = 27;
	localparam int AD_W           = 33;
	localparam int SQ_IN_W        = 23;
	localparam int TERM_W         = 2 * SQ_IN_W;
	localparam int METHOD_W       = 2;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [METHOD_W-1:0] METHOD_CBD = 2'd1;
	localparam logic [METHOD_W-1:0] METHOD_ED  = 2'd2;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef struct packed {
		logic signed [FIELD_W-1:0] elem_a;
		logic signed [FIELD_W-1:0] elem_b;
		logic                      last;
	} vda_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              bad_method;
	} vda_rsp_t;

	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [METHOD_W-1:0] method;
	} vda_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROOT,
		BK_EMIT
	} vda_bstate_t;

endpackage

### rtl/vda_front.sv
// Front end: accepts element pairs, forms the per-pair term and accumulates the running sum.
module vda_front import vda_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  vda_req_t            req,
	input  logic                method_we,
	input  logic [METHOD_W-1:0] method_wdata,
	output logic                push,
	output vda_job_t            push_data,
	input  logic                q_full
);

	localparam int DW = ELEM_WIDTH + 1;

	logic [METHOD_W-1:0]   method_q;
	logic [ELEM_WIDTH-1:0] ea;
	logic [ELEM_WIDTH-1:0] eb;
	logic signed [DW-1:0]  diff;
	logic [DW-1:0]         ad;
	logic [AD_W-1:0]       ad_wide;
	logic                  accept;
	logic                  advance;

	logic                  v_s1;
	logic [AD_W-1:0]       ad_s1;
	logic                  last_s1;
	logic [METHOD_W-1:0]   meth_s1;

	logic                  v_s2;
	logic [TERM_W-1:0]     term_s2;
	logic                  big_s2;
	logic                  last_s2;
	logic [METHOD_W-1:0]   meth_s2;

	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W+1:0]      sum_raw;
	logic [SUM_W-1:0]      sum_new;
	logic                  meth_ok;

	genvar i;
	generate
		for (i = 0; i < ELEM_WIDTH; i++) begin : g_elem
			if (i < FIELD_W) begin : g_in
				assign ea[i] = req.elem_a[i];
				assign eb[i] = req.elem_b[i];
			end else begin : g_zero
				assign ea[i] = 1'b0;
				assign eb[i] = 1'b0;
			end
		end
		for (i = 0; i < AD_W; i++) begin : g_ad
			if (i < DW) begin : g_in
				assign ad_wide[i] = ad[i];
			end else begin : g_zero
				assign ad_wide[i] = 1'b0;
			end
		end
	endgenerate

	assign diff = $signed({ea[ELEM_WIDTH-1], ea}) - $signed({eb[ELEM_WIDTH-1], eb});
	assign ad   = diff[DW-1] ? DW'(-diff) : DW'(diff);

	assign advance   = !(v_s2 && last_s2 && q_full);
	assign req_stall = !advance;
	assign accept    = req_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_CBD;
		end else if (method_we) begin
			method_q <= method_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ad_s1   <= ad_wide;
			last_s1 <= req.last;
			meth_s1 <= method_q;
			if (meth_s1 == METHOD_ED) begin
				term_s2 <= ad_s1[SQ_IN_W-1:0] * ad_s1[SQ_IN_W-1:0];
			end else begin
				term_s2 <= TERM_W'(ad_s1);
			end
			big_s2  <= (meth_s1 == METHOD_ED) && (|ad_s1[AD_W-1:SQ_IN_W]);
			last_s2 <= last_s1;
			meth_s2 <= meth_s1;
		end
	end

	assign meth_ok = (meth_s2 == METHOD_CBD) || (meth_s2 == METHOD_ED);
	assign sum_raw = {2'b00, sum_q} + {1'b0, term_s2};

	always_comb begin
		if (!meth_ok) begin
			sum_new = sum_q;
		end else if (big_s2 || (sum_raw > {2'b00, SUM_MAX})) begin
			sum_new = SUM_MAX;
		end else begin
			sum_new = sum_raw[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (advance && v_s2) begin
			sum_q <= last_s2 ? '0 : sum_new;
		end
	end

	assign push             = advance && v_s2 && last_s2;
	assign push_data.sum    = sum_new;
	assign push_data.method = meth_s2;

endmodule

### rtl/vda_queue.sv
// Short queue of finished sums between the front end and the back end.
module vda_queue import vda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  vda_job_t push_data,
	output logic     full,
	input  logic     pop,
	output vda_job_t pop_data,
	output logic     empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	vda_job_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("Queue read while empty.");

endmodule

### rtl/vda_back.sv
// Back end: turns a closed sum into a distance, by bit-pair square root if Euclidean, and holds it.
module vda_back import vda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     empty,
	input  vda_job_t pop_data,
	output logic     pop,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output vda_rsp_t rsp
);

	vda_bstate_t       state_q;
	vda_bstate_t       state_d;
	logic [SUM_W-1:0]  n_q;
	logic [SUM_W-1:0]  res_q;
	logic [SUM_W-1:0]  bit_q;
	logic [DIST_W-1:0] dist_q;
	logic              bad_q;
	logic              rsp_valid_q;
	vda_rsp_t          rsp_q;
	logic              load_out;
	logic [SUM_W:0]    trial;
	logic              take;
	logic [SUM_W-1:0]  res_nxt;

	assign trial   = {1'b0, res_q} + {1'b0, bit_q};
	assign take    = ({1'b0, n_q} >= trial);
	assign res_nxt = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					state_d = (pop_data.method == METHOD_ED) ? BK_ROOT : BK_EMIT;
				end
			end
			BK_ROOT: begin
				if (bit_q[0]) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: pop      = !empty;
			BK_EMIT: load_out = !rsp_valid_q || !rsp_stall;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q   <= pop_data.sum;
			res_q <= '0;
			bit_q <= SUM_W'(1) << (SUM_W - 1 - ((SUM_W - 1) % 2));
			bad_q <= (pop_data.method != METHOD_CBD) && (pop_data.method != METHOD_ED);
			if (pop_data.method == METHOD_CBD) begin
				dist_q <= (pop_data.sum > SUM_W'(DIST_MAX)) ? DIST_MAX
				                                          : pop_data.sum[DIST_W-1:0];
			end else begin
				dist_q <= '0;
			end
		end else if (state_q == BK_ROOT) begin
			if (take) begin
				n_q <= n_q - trial[SUM_W-1:0];
			end
			res_q <= res_nxt;
			bit_q <= bit_q >> 2;
			if (bit_q[0]) begin
				dist_q <= res_nxt[DIST_W-1:0];
			end
		end
		if (load_out) begin
			rsp_q.distance   <= dist_q;
			rsp_q.bad_method <= bad_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_root_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ROOT) |-> $onehot(bit_q))
		else $error("Square root bit register is not one-hot.");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BK_ROOT || state_q == BK_EMIT))
		else $error("Back end took a sum but did not start on it.");

endmodule

### rtl/vector_distance_accumulator_top.sv
// Top level of the vector distance accumulator.
// The block takes one element pair per cycle while req_stall is low and, on the pair marked
// last, delivers one result: the city block distance, the Euclidean distance as the
// rounded-down square root of the sum of squares, or a zero distance flagged bad_method
// for an invalid method. The front end accepts a pair every cycle unless stalled and adds
// its term to the running sum after the s1 and s2 stage registers; a closed sum then waits
// in a two-entry queue for the back end, whose square root for a Euclidean vector resolves
// one result bit per cycle, so Euclidean vectors that close faster than their roots resolve
// back up into the front end, which then stalls on the last pair until a queue entry frees.
// A result waits in an output register, so new pairs are taken while it is not yet collected.
module vector_distance_accumulator_top import vda_pkg::*; #(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  vda_req_t            req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output vda_rsp_t            rsp,
	input  logic                method_we,
	input  logic [METHOD_W-1:0] method_wdata
);

	logic     push;
	vda_job_t push_data;
	logic     q_full;
	logic     pop;
	vda_job_t pop_data;
	logic     q_empty;

	vda_front #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.method_we   (method_we),
		.method_wdata(method_wdata),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	vda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	vda_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.pop_data (pop_data),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### tb/vda_distance_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the vector distance results from the observed requests and compares them.
module vda_distance_checker import vda_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  vda_req_t            req,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  vda_rsp_t            rsp,
	input  logic                method_we,
	input  logic [METHOD_W-1:0] method_wdata,
	output int                  mismatches,
	output int                  outstanding
);

	logic [METHOD_W-1:0] method_now;
	logic [SUM_W-1:0]    running_total;
	vda_rsp_t            expected_distances[$];

	function automatic logic [63:0] saturating_sum(input logic [63:0] acc,
			input logic [63:0] term);
		if (term > SUM_MAX || acc > SUM_MAX - term) begin
			return SUM_MAX;
		end
		return acc + term;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] value);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		rest = value;
		root = '0;
		probe = 64'd1 << 62;
		while (probe > rest) begin
			probe = probe >> 2;
		end
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	task automatic absorb_pair(input vda_req_t pair);
		longint      diff;
		logic [63:0] mag;
		logic [63:0] total;
		logic [63:0] span;
		vda_rsp_t    due;
		diff = longint'(pair.elem_a) - longint'(pair.elem_b);
		mag = (diff < 0) ? -diff : diff;
		total = running_total;
		if (method_now == METHOD_CBD) begin
			total = saturating_sum(total, mag);
		end else if (method_now == METHOD_ED) begin
			total = saturating_sum(total, mag * mag);
		end
		running_total = total[SUM_W-1:0];
		if (pair.last) begin
			due.bad_method = 1'b0;
			if (method_now == METHOD_CBD) begin
				span = total;
			end else if (method_now == METHOD_ED) begin
				span = root_floor(total);
			end else begin
				span = '0;
				due.bad_method = 1'b1;
			end
			if (span > DIST_MAX) begin
				span = DIST_MAX;
			end
			due.distance = span[DIST_W-1:0];
			expected_distances.push_back(due);
			running_total = '0;
		end
	endtask

	task automatic check_result(input vda_rsp_t got);
		vda_rsp_t due;
		if (expected_distances.size() == 0) begin
			if (mismatches < 10) begin
				$display("%0t: result with no request pending: distance=%0d bad_method=%0b",
					$time, got.distance, got.bad_method);
			end
			mismatches++;
		end else begin
			due = expected_distances.pop_front();
			if (got.distance !== due.distance || got.bad_method !== due.bad_method) begin
				if (mismatches < 10) begin
					$display("%0t: distance exp %0d got %0d, bad_method exp %0b got %0b",
						$time, due.distance, got.distance, due.bad_method, got.bad_method);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_now = METHOD_CBD;
			running_total = '0;
			expected_distances.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp);
			end
			if (req_valid && !req_stall) begin
				absorb_pair(req);
			end
			if (method_we) begin
				method_now = method_wdata;
			end
			outstanding = expected_distances.size();
		end
	end

endmodule

### tb/tb_vector_distance_accumulator_top.sv
`timescale 1ns / 100ps
// Testbench top for the vector distance accumulator: clock, reset, request and result traffic.
module tb_vector_distance_accumulator_top;
	import vda_pkg::*;

	localparam logic [METHOD_W-1:0] METHOD_NONE  = 2'd0;
	localparam logic [METHOD_W-1:0] METHOD_SPARE = 2'd3;
	localparam int RANDOM_ITEMS  = 1500;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	vda_req_t            req;
	logic                rsp_valid;
	logic                rsp_stall;
	vda_rsp_t            rsp;
	logic                method_we;
	logic [METHOD_W-1:0] method_wdata;
	int                  mismatches;
	int                  outstanding;
	int                  quiet_cycles;
	logic                calm;
	logic                hold_off_req;
	logic                hold_off_done;

	vector_distance_accumulator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.method_we    (method_we),
		.method_wdata (method_wdata)
	);

	vda_distance_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.method_we    (method_we),
		.method_wdata (method_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic logic [FIELD_W-1:0] pick_elem();
		case ($urandom_range(0, 5))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return 16'($urandom_range(0, 511) - 256);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	function automatic logic [METHOD_W-1:0] pick_method();
		case ($urandom_range(0, 7))
			0: begin
				return METHOD_NONE;
			end
			1: begin
				return METHOD_SPARE;
			end
			2, 3, 4: begin
				return METHOD_CBD;
			end
			default: begin
				return METHOD_ED;
			end
		endcase
	endfunction

	task automatic send_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
			input logic lst);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.elem_a = a;
		req.elem_b = b;
		req.last = lst;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_method(input logic [METHOD_W-1:0] value);
		settle();
		method_we = 1'b1;
		method_wdata = value;
		@(negedge clk);
		method_we = 1'b0;
	endtask

	// Result side: a random hold-off before each result, and one long hold-off when asked.
	initial begin
		int gap;
		rsp_stall = 1'b0;
		hold_off_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = draw_gap();
			rsp_stall = 1'b1;
			repeat (gap) @(negedge clk);
			rsp_stall = 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int vectors;
		int len;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		method_we = 1'b0;
		method_wdata = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// City block under the reset setting.
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h0100, 16'h0080, 1'b0);
		send_pair(16'hFF00, 16'h0100, 1'b0);
		send_pair(16'h0005, 16'h0005, 1'b1);
		send_pair(16'h04D2, 16'h04D2, 1'b1);
		// A request opened under city block and closed under Euclidean.
		send_pair(16'h0064, 16'h0000, 1'b0);
		write_method(METHOD_ED);
		send_pair(16'h0000, 16'h012C, 1'b1);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h0300, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0400, 1'b1);
		send_pair(16'h0001, 16'h0000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b1);
		write_method(METHOD_NONE);
		send_pair(16'h0064, 16'h0032, 1'b0);
		send_pair(16'h000A, 16'h0014, 1'b1);
		write_method(METHOD_SPARE);
		send_pair(16'h0007, 16'h0008, 1'b1);
		write_method(METHOD_ED);
		send_pair(16'h0001, 16'h0002, 1'b1);
		// Pairs taken under an invalid method add nothing to the open vector.
		write_method(METHOD_NONE);
		send_pair(16'h01F4, 16'h0000, 1'b0);
		write_method(METHOD_CBD);
		send_pair(16'h0001, 16'h0000, 1'b1);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			write_method(pick_method());
			calm = ($urandom_range(0, 3) == 0);
			vectors = $urandom_range(4, 16);
			repeat (vectors) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_pair(pick_elem(), pick_elem(), i == len - 1);
					sent++;
					if (sent >= 50) begin
						hold_off_req = 1'b1;
					end
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_pair(pick_elem(), pick_elem(), 1'b0);
					sent++;
				end
			end
		end
		calm = 1'b0;
		send_pair(pick_elem(), pick_elem(), 1'b1);
		settle();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### vector_distance_accumulator_top.f
rtl/vda_pkg.sv
rtl/vda_front.sv
rtl/vda_queue.sv
rtl/vda_back.sv
rtl/vector_distance_accumulator_top.sv
tb/vda_distance_checker.sv
tb/tb_vector_distance_accumulator_top.sv
